FILE: hw/rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int TIME_W     = 48;
    localparam int CH_W       = 8;
    localparam int TAG_W      = 16;
    localparam int TOF_W      = 31;
    localparam int TCNT_W     = 32;
    localparam int WIN_W      = 24;
    localparam int SF_W       = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_CHANNEL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREV_ONLY_MODE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR    = 8'd3;

    localparam logic [CH_W-1:0]  RST_TRIGGER_CHANNEL = 8'd64;
    localparam logic [WIN_W-1:0] RST_WINDOW_TICKS    = 24'd16000;
    localparam logic             RST_PREV_ONLY_MODE  = 1'b0;
    localparam logic [SF_W-1:0]  RST_SCALE_FACTOR    = 10'd10;

    typedef struct packed {
        logic [CH_W-1:0]  trigger_channel;
        logic [WIN_W-1:0] window_ticks;
        logic             prev_only_mode;
        logic [SF_W-1:0]  scale_factor;
    } tcw_cfg_t;

    // One classified hit as it travels from the front end to the pairing engine.
    typedef struct packed {
        logic [TIME_W-1:0] hit_time;
        logic [CH_W-1:0]   channel_index;
        logic [TAG_W-1:0]  hit_tag;
        logic              is_trig;
        logic [TCNT_W-1:0] tcount;
    } tcw_item_t;

    typedef struct packed {
        logic idle;
        logic pend_valid;
        logic count_ok;
    } tcw_status_t;

endpackage

FILE: hw/rtl/tcw_ifs.sv
interface tcw_hit_if;
    import tcw_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] hit_time;
    logic [CH_W-1:0]   channel_index;
    logic [TAG_W-1:0]  hit_tag;
    modport source (output valid, output hit_time, output channel_index, output hit_tag,
                    input ready);
    modport sink   (input valid, input hit_time, input channel_index, input hit_tag,
                    output ready);
endinterface

interface tcw_result_if;
    import tcw_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [TOF_W-1:0]  tof_scaled;
    logic [CH_W-1:0]          pair_channel;
    logic [TIME_W-1:0]        pair_time;
    logic [TAG_W-1:0]         pair_tag;
    logic [TCNT_W-1:0]        trigger_count;
    logic                     last;
    modport source (output valid, output tof_scaled, output pair_channel, output pair_time,
                    output pair_tag, output trigger_count, output last, input ready);
    modport sink   (input valid, input tof_scaled, input pair_channel, input pair_time,
                    input pair_tag, input trigger_count, input last, output ready);
endinterface

interface tcw_cfg_if;
    import tcw_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/tof_coincidence_window_core.sv
// Time-of-flight coincidence finder. Hits are accepted on the hit channel in
// time order and classified against the trigger channel by the front end, which
// buffers up to two hits. The pairing engine takes one hit at a time. In
// all-pairs mode it stores the hit in a ring of WINDOW_DEPTH entries, ages out
// old entries and then scans the window one stored hit at a time through the
// read, compare, multiply and finish steps; the finish step stalls while a
// new pair and a held pair meet a full output register. In previous-trigger
// mode a non-trigger hit after a trigger goes to the multiply and finish steps.
// Each pair within the window yields one result transfer; the last transfer
// caused by a hit carries last. Configuration registers may only be written
// while no hit is in flight.
module tof_coincidence_window_core #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    tcw_hit_if.sink       hit,
    tcw_result_if.source  result,
    tcw_cfg_if.sink       cfg
);
    import tcw_pkg::*;

    tcw_cfg_t    cfg_reg;
    tcw_item_t   q_item;
    logic        q_valid;
    logic        q_ready;
    tcw_status_t status;

    // The register file always takes a write transfer; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_channel <= RST_TRIGGER_CHANNEL;
            cfg_reg.window_ticks    <= RST_WINDOW_TICKS;
            cfg_reg.prev_only_mode  <= RST_PREV_ONLY_MODE;
            cfg_reg.scale_factor    <= RST_SCALE_FACTOR;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TRIGGER_CHANNEL: cfg_reg.trigger_channel <= cfg.data[CH_W-1:0];
                REG_WINDOW_TICKS:    cfg_reg.window_ticks    <= cfg.data[WIN_W-1:0];
                REG_PREV_ONLY_MODE:  cfg_reg.prev_only_mode  <= cfg.data[0];
                REG_SCALE_FACTOR:    cfg_reg.scale_factor    <= cfg.data[SF_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front end: trigger classification, trigger counting and the hit queue.
    tcw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .hit     (hit),
        .cfg     (cfg_reg),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    // Back end: window store, pairing scan and result output register.
    tcw_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .result  (result),
        .status  (status)
    );

    // A pair held back for the last marker must be sent before the next hit is taken.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        status.idle |-> !status.pend_valid)
        else $error("pairing engine idle with a held result");

    // The window never claims more entries than the store holds.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count_ok)
        else $error("window count exceeds depth");

    // A held result can only be pending while the engine is busy with its hit.
    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.pend_valid |=> (status.pend_valid || $past(!status.idle)))
        else $error("held result appeared outside a scan");

endmodule

FILE: hw/rtl/tcw_front.sv
module tcw_front (
    input  logic                clk,
    input  logic                rst_n,
    tcw_hit_if.sink             hit,
    input  tcw_pkg::tcw_cfg_t   cfg,
    output tcw_pkg::tcw_item_t  q_item,
    output logic                q_valid,
    input  logic                q_ready
);
    import tcw_pkg::*;

    // Two-entry queue in front of the pairing engine.
    tcw_item_t         buf_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic [TCNT_W-1:0] trig_cnt_reg;

    logic      push;
    logic      pop;
    logic      is_trig;
    tcw_item_t new_item;

    assign is_trig   = (hit.channel_index == cfg.trigger_channel);
    assign hit.ready = (cnt_reg != 2'd2);
    assign push      = hit.valid && hit.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_item    = buf_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.hit_time      = hit.hit_time;
        new_item.channel_index = hit.channel_index;
        new_item.hit_tag       = hit.hit_tag;
        new_item.is_trig       = is_trig;
        new_item.tcount        = trig_cnt_reg + TCNT_W'(is_trig);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            cnt_reg      <= 2'd0;
            trig_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg   <= ~wr_ptr_reg;
                trig_cnt_reg <= new_item.tcount;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: hw/rtl/tcw_back.sv
module tcw_back #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcw_pkg::tcw_cfg_t    cfg,
    input  tcw_pkg::tcw_item_t   q_item,
    input  logic                 q_valid,
    output logic                 q_ready,
    tcw_result_if.source         result,
    output tcw_pkg::tcw_status_t status
);
    import tcw_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int DT_W  = 38;
    localparam int PR_W  = DT_W + SF_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);
    localparam logic signed [TIME_W:0] DT_FLOOR = -(49'sd1 <<< (DT_W - 2));
    localparam logic signed [PR_W-1:0] Q_MAX = PR_W'(64'sd1073741823);
    localparam logic signed [PR_W-1:0] Q_MIN = -(PR_W'(64'sd1073741824));

    typedef enum logic [2:0] {
        S_IDLE, S_AGE_RD, S_AGE_CHK, S_SCAN_RD, S_SCAN_CHK, S_MUL, S_FIN, S_FLUSH
    } state_t;

    function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(WINDOW_DEPTH))
        begin
            s = s - (IDX_W+1)'(WINDOW_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic signed [DT_W-1:0] clamp_dt(logic signed [TIME_W:0] d);
        logic signed [TIME_W:0] c;
        c = (d < DT_FLOOR) ? DT_FLOOR : d;
        return c[DT_W-1:0];
    endfunction

    // Window store.
    logic [TIME_W-1:0] mem_time [WINDOW_DEPTH];
    logic [CH_W-1:0]   mem_ch   [WINDOW_DEPTH];
    logic [TAG_W-1:0]  mem_tag  [WINDOW_DEPTH];
    logic [TIME_W-1:0] rd_time_reg;
    logic [CH_W-1:0]   rd_ch_reg;
    logic [TAG_W-1:0]  rd_tag_reg;

    state_t                  state_reg;
    tcw_item_t               cur_reg;
    logic [IDX_W-1:0]        head_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        idx_reg;
    logic                    prev_valid_reg;
    logic [TIME_W-1:0]       prev_time_reg;
    logic signed [DT_W-1:0]  dt_reg;
    logic                    ok_reg;
    logic                    final_reg;
    logic [CH_W-1:0]         cand_ch_reg;
    logic [TIME_W-1:0]       cand_time_reg;
    logic [TAG_W-1:0]        cand_tag_reg;
    logic signed [PR_W-1:0]  prod_reg;
    logic                    pend_valid_reg;
    logic signed [TOF_W-1:0] pend_tof_reg;
    logic [CH_W-1:0]         pend_ch_reg;
    logic [TIME_W-1:0]       pend_time_reg;
    logic [TAG_W-1:0]        pend_tag_reg;
    logic                    out_valid_reg;
    logic signed [TOF_W-1:0] out_tof_reg;
    logic [CH_W-1:0]         out_ch_reg;
    logic [TIME_W-1:0]       out_time_reg;
    logic [TAG_W-1:0]        out_tag_reg;
    logic [TCNT_W-1:0]       out_tcnt_reg;
    logic                    out_last_reg;

    logic                    take;
    logic                    wr_en;
    logic [IDX_W-1:0]        h1;
    logic [CNT_W-1:0]        c1;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [TIME_W:0]  age_d;
    logic signed [TIME_W:0]  win_s;
    logic signed [TIME_W:0]  prev_d;
    logic signed [TIME_W:0]  sc_d;
    logic                    sc_pair;
    logic                    old_trig;
    logic signed [PR_W-1:0]  q_adj;
    logic signed [PR_W-1:0]  q_div;
    logic signed [TOF_W-1:0] q_sat;
    logic                    out_free;
    logic                    out_load;
    logic [CNT_W-1:0]        idx_inc;

    assign q_ready  = (state_reg == S_IDLE);
    assign take     = q_valid && q_ready;
    assign wr_en    = take && !cfg.prev_only_mode;
    assign out_free = !out_valid_reg || result.ready;
    assign win_s    = $signed({25'd0, cfg.window_ticks});
    assign idx_inc  = idx_reg + CNT_W'(1);
    // The output register takes a new transfer this cycle.
    assign out_load = ((state_reg == S_FIN) && ok_reg && pend_valid_reg && out_free) ||
                      ((state_reg == S_FLUSH) && pend_valid_reg && out_free);

    always_comb
    begin
        if (count_reg == DEPTH_C)
        begin
            h1 = wrap_add(head_reg, IDX_W'(1));
            c1 = DEPTH_C - CNT_W'(1);
        end
        else
        begin
            h1 = head_reg;
            c1 = count_reg;
        end
        wr_addr = wrap_add(h1, c1[IDX_W-1:0]);
        rd_addr = (state_reg == S_SCAN_RD) ? wrap_add(head_reg, idx_reg[IDX_W-1:0]) : head_reg;
        age_d   = $signed({1'b0, cur_reg.hit_time}) - $signed({1'b0, rd_time_reg});
        prev_d  = $signed({1'b0, q_item.hit_time}) - $signed({1'b0, prev_time_reg});
        old_trig = (rd_ch_reg == cfg.trigger_channel);
        sc_pair  = old_trig != cur_reg.is_trig;
        sc_d     = old_trig ? age_d : -age_d;
        q_adj    = prod_reg + ((prod_reg < 0) ? PR_W'(15) : PR_W'(0));
        q_div    = q_adj >>> 4;
        if (q_div > Q_MAX)
        begin
            q_sat = TOF_W'(Q_MAX);
        end
        else if (q_div < Q_MIN)
        begin
            q_sat = TOF_W'(Q_MIN);
        end
        else
        begin
            q_sat = q_div[TOF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_time[wr_addr] <= q_item.hit_time;
            mem_ch[wr_addr]   <= q_item.channel_index;
            mem_tag[wr_addr]  <= q_item.hit_tag;
        end
        rd_time_reg <= mem_time[rd_addr];
        rd_ch_reg   <= mem_ch[rd_addr];
        rd_tag_reg  <= mem_tag[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            prev_valid_reg <= 1'b0;
            prev_time_reg  <= '0;
            ok_reg         <= 1'b0;
            final_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        cur_reg <= q_item;
                        if (cfg.prev_only_mode)
                        begin
                            if (q_item.is_trig)
                            begin
                                prev_valid_reg <= 1'b1;
                                prev_time_reg  <= q_item.hit_time;
                            end
                            else if (prev_valid_reg)
                            begin
                                dt_reg        <= clamp_dt(prev_d);
                                ok_reg        <= (prev_d <= win_s);
                                cand_ch_reg   <= q_item.channel_index;
                                cand_time_reg <= q_item.hit_time;
                                cand_tag_reg  <= q_item.hit_tag;
                                final_reg     <= 1'b1;
                                state_reg     <= S_MUL;
                            end
                        end
                        else
                        begin
                            head_reg  <= h1;
                            count_reg <= c1 + CNT_W'(1);
                            final_reg <= 1'b0;
                            state_reg <= S_AGE_RD;
                        end
                    end
                end
                S_AGE_RD:
                begin
                    state_reg <= S_AGE_CHK;
                end
                S_AGE_CHK:
                begin
                    if (age_d < 0)
                    begin
                        head_reg  <= '0;
                        count_reg <= '0;
                        state_reg <= S_FLUSH;
                    end
                    else if (age_d > win_s)
                    begin
                        head_reg  <= wrap_add(head_reg, IDX_W'(1));
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_AGE_RD;
                    end
                    else if (count_reg <= CNT_W'(1))
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    dt_reg <= clamp_dt(sc_d);
                    ok_reg <= sc_pair && (sc_d <= win_s);
                    if (old_trig)
                    begin
                        cand_ch_reg   <= cur_reg.channel_index;
                        cand_time_reg <= cur_reg.hit_time;
                        cand_tag_reg  <= cur_reg.hit_tag;
                    end
                    else
                    begin
                        cand_ch_reg   <= rd_ch_reg;
                        cand_time_reg <= rd_time_reg;
                        cand_tag_reg  <= rd_tag_reg;
                    end
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg  <= dt_reg * $signed({1'b0, cfg.scale_factor});
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // A new pair pushes the held one out; the held one leaves
                    // with last set only once the scan is over.
                    if (!(ok_reg && pend_valid_reg && !out_free))
                    begin
                        if (ok_reg)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_tof_reg   <= pend_tof_reg;
                                out_ch_reg    <= pend_ch_reg;
                                out_time_reg  <= pend_time_reg;
                                out_tag_reg   <= pend_tag_reg;
                                out_tcnt_reg  <= cur_reg.tcount;
                                out_last_reg  <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_tof_reg   <= q_sat;
                            pend_ch_reg    <= cand_ch_reg;
                            pend_time_reg  <= cand_time_reg;
                            pend_tag_reg   <= cand_tag_reg;
                        end
                        if (final_reg || !(idx_inc + CNT_W'(1) < count_reg))
                        begin
                            state_reg <= S_FLUSH;
                        end
                        else
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_tof_reg    <= pend_tof_reg;
                        out_ch_reg     <= pend_ch_reg;
                        out_time_reg   <= pend_time_reg;
                        out_tag_reg    <= pend_tag_reg;
                        out_tcnt_reg   <= cur_reg.tcount;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.tof_scaled    = out_tof_reg;
    assign result.pair_channel  = out_ch_reg;
    assign result.pair_time     = out_time_reg;
    assign result.pair_tag      = out_tag_reg;
    assign result.trigger_count = out_tcnt_reg;
    assign result.last          = out_last_reg;

    assign status.idle       = (state_reg == S_IDLE);
    assign status.pend_valid = pend_valid_reg;
    assign status.count_ok   = (count_reg <= DEPTH_C);

endmodule

FILE: tb/tb_tof_coincidence_window_core.sv
module tb_tof_coincidence_window_core;
    import tcw_pkg::*;

    // One expected or observed pair result, at the widths of the result channel.
    typedef struct {
        logic signed [TOF_W-1:0] tof;
        logic [CH_W-1:0]         ch;
        logic [TIME_W-1:0]       ptime;
        logic [TAG_W-1:0]        tag;
        logic [TCNT_W-1:0]       tcount;
        logic                    last;
    } pair_t;

    // Tracks the coincidence state of the block and holds the pairs still owed.
    class pair_scoreboard;
        localparam int DEPTH = 32;

        logic [TIME_W-1:0] ring_time [DEPTH];
        logic [CH_W-1:0]   ring_ch   [DEPTH];
        logic [TAG_W-1:0]  ring_tag  [DEPTH];
        int                head;
        int                count;
        bit                have_trig;
        logic [TIME_W-1:0] trig_time;
        logic [TCNT_W-1:0] trig_seen;

        logic [CH_W-1:0]   trig_ch;
        logic [WIN_W-1:0]  win_ticks;
        logic              prev_mode;
        logic [SF_W-1:0]   scale;

        pair_t             pending_pairs [$];
        int                errors;

        function void init();
            head      = 0;
            count     = 0;
            have_trig = 0;
            trig_time = '0;
            trig_seen = '0;
            trig_ch   = RST_TRIGGER_CHANNEL;
            win_ticks = RST_WINDOW_TICKS;
            prev_mode = RST_PREV_ONLY_MODE;
            scale     = RST_SCALE_FACTOR;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TRIGGER_CHANNEL: trig_ch   = data[CH_W-1:0];
                REG_WINDOW_TICKS:    win_ticks = data[WIN_W-1:0];
                REG_PREV_ONLY_MODE:  prev_mode = data[0];
                REG_SCALE_FACTOR:    scale     = data[SF_W-1:0];
                default: ;
            endcase
        endfunction

        // Queues one pair if its time of flight lies inside the window.
        function int add_pair(longint dt, logic [TIME_W-1:0] t, logic [CH_W-1:0] ch,
                              logic [TAG_W-1:0] tag);
            longint q;
            pair_t  p;
            if (dt > longint'(win_ticks))
                return 0;
            q = (dt * longint'(scale)) / 16;
            if (q > 64'sd1073741823)
                q = 64'sd1073741823;
            if (q < -64'sd1073741824)
                q = -64'sd1073741824;
            p.tof    = q[TOF_W-1:0];
            p.ch     = ch;
            p.ptime  = t;
            p.tag    = tag;
            p.tcount = trig_seen;
            p.last   = 1'b0;
            pending_pairs.push_back(p);
            return 1;
        endfunction

        // Called on every accepted hit transfer.
        function void note_hit(logic [TIME_W-1:0] t, logic [CH_W-1:0] ch,
                               logic [TAG_W-1:0] tag);
            bit     is_trig;
            bit     old_trig;
            int     n;
            int     k;
            int     slot;
            longint d;
            is_trig = (ch == trig_ch);
            n = 0;
            if (is_trig)
                trig_seen++;
            if (prev_mode) begin
                if (is_trig) begin
                    trig_time = t;
                    have_trig = 1;
                end
                else if (have_trig) begin
                    n += add_pair(longint'(t) - longint'(trig_time), t, ch, tag);
                end
            end
            else begin
                // A full ring drops its oldest hit before the new one goes in.
                if (count >= DEPTH) begin
                    head  = (head + 1) % DEPTH;
                    count = DEPTH - 1;
                end
                slot = (head + count) % DEPTH;
                ring_time[slot] = t;
                ring_ch[slot]   = ch;
                ring_tag[slot]  = tag;
                count++;
                while (count > 0) begin
                    d = longint'(t) - longint'(ring_time[head]);
                    if (d < 0) begin
                        // A hit earlier than the oldest one flushes everything.
                        head  = 0;
                        count = 0;
                        return;
                    end
                    if (d > longint'(win_ticks)) begin
                        head = (head + 1) % DEPTH;
                        count--;
                    end
                    else begin
                        break;
                    end
                end
                for (int i = 0; i + 1 < count; i++) begin
                    k = (head + i) % DEPTH;
                    old_trig = (ring_ch[k] == trig_ch);
                    if (old_trig && !is_trig)
                        n += add_pair(longint'(t) - longint'(ring_time[k]), t, ch, tag);
                    else if (!old_trig && is_trig)
                        n += add_pair(longint'(ring_time[k]) - longint'(t), ring_time[k],
                                      ring_ch[k], ring_tag[k]);
                end
            end
            if (n > 0)
                pending_pairs[$].last = 1'b1;
        endfunction

        // Called on every accepted result transfer.
        function void check_result(pair_t got);
            pair_t want;
            if (pending_pairs.size() == 0) begin
                $display("%0t: unexpected result tof=%0d ch=%0d time=%0h tag=%0h",
                         $time, got.tof, got.ch, got.ptime, got.tag);
                errors++;
                return;
            end
            want = pending_pairs.pop_front();
            if (got.tof !== want.tof) begin
                $display("%0t: tof_scaled expected %0d actual %0d", $time, want.tof, got.tof);
                errors++;
            end
            if (got.ch !== want.ch) begin
                $display("%0t: pair_channel expected %0d actual %0d", $time, want.ch, got.ch);
                errors++;
            end
            if (got.ptime !== want.ptime) begin
                $display("%0t: pair_time expected %0h actual %0h", $time, want.ptime,
                         got.ptime);
                errors++;
            end
            if (got.tag !== want.tag) begin
                $display("%0t: pair_tag expected %0h actual %0h", $time, want.tag, got.tag);
                errors++;
            end
            if (got.tcount !== want.tcount) begin
                $display("%0t: trigger_count expected %0d actual %0d", $time, want.tcount,
                         got.tcount);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // Long enough for the slowest hit: aging a full ring and scanning it.
    localparam int SETTLE_CYCLES = 400;

    logic clk;
    logic rst_n;

    tcw_hit_if    hit_bus ();
    tcw_result_if res_bus ();
    tcw_cfg_if    cfg_bus ();

    tof_coincidence_window_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .hit    (hit_bus),
        .result (res_bus),
        .cfg    (cfg_bus)
    );

    pair_scoreboard coinc_sb;
    bit             gaps_on;
    int             ready_hold;
    logic [TIME_W-1:0] stamp;

    always #4 clk = ~clk;

    // The result side stalls in random bursts while gaps are enabled and
    // checks every accepted result transfer against the oldest owed pair.
    always @(posedge clk) begin
        pair_t got;
        if (res_bus.valid && res_bus.ready) begin
            got.tof    = res_bus.tof_scaled;
            got.ch     = res_bus.pair_channel;
            got.ptime  = res_bus.pair_time;
            got.tag    = res_bus.pair_tag;
            got.tcount = res_bus.trigger_count;
            got.last   = res_bus.last;
            coinc_sb.check_result(got);
        end
        if (ready_hold > 0) begin
            ready_hold--;
            res_bus.ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 12) == 0) begin
            ready_hold = $urandom_range(1, 19) - 1;
            res_bus.ready <= 1'b0;
        end
        else begin
            res_bus.ready <= 1'b1;
        end
    end

    // Sends one hit; valid stays high between back-to-back transfers and is
    // only lowered at the start of an idle burst.
    task automatic send_hit(logic [TIME_W-1:0] t, logic [CH_W-1:0] ch,
                            logic [TAG_W-1:0] tag);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            hit_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        hit_bus.valid         <= 1'b1;
        hit_bus.hit_time      <= t;
        hit_bus.channel_index <= ch;
        hit_bus.hit_tag       <= tag;
        do @(posedge clk); while (!hit_bus.ready);
        coinc_sb.note_hit(t, ch, tag);
    endtask

    // Pauses the hit stream until every owed pair has come back, then lets
    // any hit that yields no pair finish inside the block.
    task automatic drain();
        hit_bus.valid <= 1'b0;
        @(posedge clk);
        while (coinc_sb.pending_pairs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Valid is left high so that back-to-back writes never toggle it within
    // one step; cfg_release lowers it after the last write of a group.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
        coinc_sb.write_reg(idx, data);
    endtask

    task automatic cfg_release();
        cfg_bus.valid <= 1'b0;
    endtask

    // Mostly forward-moving timestamps with random channels; now and then a
    // large jump that ages the window out or a step backward that can flush it.
    task automatic random_hits(int n);
        logic [CH_W-1:0] ch;
        longint          span;
        int              pick;
        span = longint'(coinc_sb.win_ticks) / 8 + 1;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                stamp = stamp - TIME_W'($urandom_range(1, 5000));
            else if (pick < 9)
                stamp = stamp + TIME_W'(span * 12 + $urandom_range(0, 999));
            else if (pick < 30)
                stamp = stamp;
            else
                stamp = stamp + TIME_W'($urandom_range(0, int'(span > 1000000 ? 1000000 : span)));
            pick = $urandom_range(0, 8);
            if (pick < 3)
                ch = coinc_sb.trig_ch;
            else if (pick < 6)
                ch = CH_W'($urandom_range(0, 3));
            else
                ch = CH_W'($urandom_range(0, 255));
            send_hit(stamp, ch, TAG_W'($urandom));
        end
    endtask

    initial begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        gaps_on               = 1'b1;
        ready_hold            = 0;
        hit_bus.valid         = 1'b0;
        hit_bus.hit_time      = '0;
        hit_bus.channel_index = '0;
        hit_bus.hit_tag       = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = '0;
        cfg_bus.data          = '0;
        res_bus.ready         = 1'b0;
        coinc_sb = new();
        coinc_sb.init();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed hits at the reset settings: trigger channel 64, window 16000.
        send_hit(48'd0, 8'd64, 16'h0000);
        send_hit(48'd100, 8'd1, 16'hFFFF);
        send_hit(48'd100, 8'd64, 16'h1234);     // zero time of flight
        send_hit(48'd200, 8'd64, 16'h0001);     // trigger against trigger: no pair
        send_hit(48'd300, 8'd255, 16'hABCD);
        send_hit(48'd16300, 8'd2, 16'h5555);    // exactly on the window edge
        send_hit(48'd16301, 8'd64, 16'hAAAA);   // ages out the oldest entries
        send_hit(48'd50, 8'd3, 16'h0F0F);       // earlier than the oldest: flush
        send_hit(48'd60, 8'd1, 16'h00FF);
        send_hit(48'd500, 8'd1, 16'hFF00);
        send_hit(48'd300, 8'd64, 16'h7777);     // earlier stored hits give negative flight
        send_hit(48'hFFFF_FFFF_FFFF, 8'd7, 16'h8001);
        send_hit(48'hFFFF_FFFF_FFFF, 8'd64, 16'h4002);
        send_hit(48'hFFFF_FFFF_FFFF, 8'd64, 16'h2004);
        stamp = 48'd1000;
        random_hits(35);
        drain();

        // Short window, top scale, a new trigger channel, and writes to
        // indexes that do not exist.
        write_reg(REG_TRIGGER_CHANNEL, 24'd5);
        write_reg(REG_WINDOW_TICKS, 24'd200);
        write_reg(REG_SCALE_FACTOR, 24'd1023);
        write_reg(8'd4, 24'hFFFFFF);
        write_reg(8'd255, 24'h123456);
        cfg_release();
        stamp = 48'h8000_0000_0000;
        random_hits(35);
        drain();

        // Previous-trigger mode, starting with a hit that has no trigger yet.
        write_reg(REG_PREV_ONLY_MODE, 24'd1);
        cfg_release();
        send_hit(stamp, 8'd9, 16'h3C3C);
        send_hit(stamp + 48'd10, 8'd5, 16'hC3C3);
        send_hit(stamp + 48'd20, 8'd9, 16'h1111);
        stamp = stamp + 48'd20;
        random_hits(35);
        drain();

        // Widest window, zero scale, trigger on channel zero.
        write_reg(REG_PREV_ONLY_MODE, 24'd0);
        write_reg(REG_WINDOW_TICKS, 24'hFFFFFF);
        write_reg(REG_SCALE_FACTOR, 24'd0);
        write_reg(REG_TRIGGER_CHANNEL, 24'd0);
        cfg_release();
        stamp = 48'h0000_1000_0000;
        random_hits(30);
        drain();

        // Zero window with unit scale, trigger on the top channel, then the
        // same in previous-trigger mode.
        write_reg(REG_WINDOW_TICKS, 24'd0);
        write_reg(REG_SCALE_FACTOR, 24'd1);
        write_reg(REG_TRIGGER_CHANNEL, 24'd255);
        cfg_release();
        random_hits(20);
        drain();
        write_reg(REG_PREV_ONLY_MODE, 24'd1);
        cfg_release();
        random_hits(15);
        drain();

        // Closing stretch at full rate on both sides.
        write_reg(REG_PREV_ONLY_MODE, 24'd0);
        write_reg(REG_WINDOW_TICKS, 24'd3000);
        write_reg(REG_SCALE_FACTOR, 24'd10);
        write_reg(REG_TRIGGER_CHANNEL, 24'd64);
        cfg_release();
        gaps_on = 1'b0;
        random_hits(40);
        drain();

        if (coinc_sb.errors == 0 && coinc_sb.pending_pairs.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #(8 * 2000000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
